// File: rtl/core/kdc_pkg.sv
// Package: marker table, schema table and front-to-back command type.
package kdc_pkg;

    localparam int TABLE_MARKERS = 32;
    localparam int TABLE_SCHEMAS = 8;
    localparam int MAX_LEN       = 18;
    localparam int MAX_SCHEMA_MK = 9;

    // Scan mode codes
    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_TOKEN = 2'd1;
    localparam logic [1:0] MODE_STRIP = 2'd2;

    // One command from the front end: up to three window pushes plus end flag
    typedef struct packed {
        logic [1:0] push_cnt;
        logic [7:0] char0;
        logic [7:0] char1;
        logic [7:0] char2;
        logic       stream_end;
    } kdc_cmd_t;

    typedef logic [MAX_LEN*8-1:0] mk_text_t;

    // Marker text, first character in the lowest byte
    function automatic mk_text_t mk_text(input int idx);
        string s;
        mk_text_t v;
        case (idx)
            0: s = {"ms_", "summary"};         1: s = "stringerfemloads";
            2: s = {"skin_", "flows"};         3: s = {"aux_skin_", "input"};
            4: s = {"aux_stringer_", "input"}; 5: s = "stringer";
            6: s = "skin";                     7: s = "buckling";
            8: s = "crippling";                9: s = "bay id";
            10: s = "fem load case";           11: s = "nx";
            12: s = "nxy";                     13: s = {"msstr_", "buck"};
            14: s = "rivet";                   15: s = "bacr15fv";
            16: s = "shear";                   17: s = "pitch";
            18: s = "rivet diameter";          19: s = "bolt";
            20: s = "torque";                  21: s = "preload";
            22: s = "bolt diameter";           23: s = "shank";
            24: s = "frame";                   25: s = "station";
            26: s = "moment of inertia";       27: s = "bending";
            28: s = "panel";                   29: s = "buckling";
            30: s = {"sigma_", "cr"};          31: s = "kc";
            default: s = "";
        endcase
        v = '0;
        for (int i = 0; i < s.len(); i++) v[i*8 +: 8] = s[i];
        return v;
    endfunction

    function automatic int mk_len(input int idx);
        case (idx)
            0: return 10;  1: return 16;  2: return 10;  3: return 14;
            4: return 18;  5: return 8;   6: return 4;   7: return 8;
            8: return 9;   9: return 6;   10: return 13; 11: return 2;
            12: return 3;  13: return 10; 14: return 5;  15: return 8;
            16: return 5;  17: return 5;  18: return 14; 19: return 4;
            20: return 6;  21: return 7;  22: return 13; 23: return 5;
            24: return 5;  25: return 7;  26: return 17; 27: return 7;
            28: return 5;  29: return 8;  30: return 8;  31: return 2;
            default: return 0;
        endcase
    endfunction

    function automatic int sc_first(input int s);
        case (s)
            0: return 0;  1: return 9;  2: return 14; 3: return 19;
            4: return 24; 5: return 28; default: return 32;
        endcase
    endfunction

    function automatic int sc_count(input int s);
        case (s)
            0: return 9; 1: return 5; 2: return 5; 3: return 5;
            4: return 4; 5: return 4; default: return 0;
        endcase
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

endpackage

// File: rtl/core/kdc_front.sv
// Front end: tag stripping, tokenizing, lowercasing into window push commands.
module kdc_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      scan_mode,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            in_part_end,
    input  logic            in_stream_end,
    output logic            in_ready,
    output logic            cmd_valid,
    output kdc_pkg::kdc_cmd_t cmd,
    input  logic            cmd_ready
);
    import kdc_pkg::*;

    logic       inside_tag_reg, inside_tag_next;
    logic [7:0] held_char_reg, held_char_next;
    logic [1:0] tok_reg, tok_next;
    kdc_cmd_t   c;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign cmd       = c;

    // Classify one byte
    always_comb begin
        logic [7:0] lc;
        logic       strip, printable;
        lc        = to_lower(in_byte);
        strip     = scan_mode[1];
        printable = in_byte >= 8'd32 && in_byte < 8'd127 && in_byte != 8'h20
                    && in_byte != 8'h2C && in_byte != 8'h3B;
        inside_tag_next = inside_tag_reg;
        held_char_next  = held_char_reg;
        tok_next        = tok_reg;
        c               = '0;
        c.stream_end    = in_stream_end;
        if (scan_mode == MODE_RAW) begin
            c.push_cnt = 2'd1;
            c.char0    = lc;
        end else if (in_byte == 8'h00) begin
            // NUL skipped
        end else if (strip && in_byte == 8'h3C) begin
            inside_tag_next = 1'b1;
            if (tok_reg == 2'd2) begin
                c.push_cnt = 2'd1;
                c.char0    = 8'h20;
            end
            tok_next       = 2'd0;
            held_char_next = 8'h00;
        end else if (strip && in_byte == 8'h3E) begin
            inside_tag_next = 1'b0;
        end else if (strip && inside_tag_reg) begin
            // inside markup
        end else if (printable) begin
            case (tok_reg)
                2'd0: begin
                    held_char_next = lc;
                    tok_next       = 2'd1;
                end
                2'd1: begin
                    c.push_cnt = 2'd2;
                    c.char0    = held_char_reg;
                    c.char1    = lc;
                    tok_next   = 2'd2;
                end
                default: begin
                    c.push_cnt = 2'd1;
                    c.char0    = lc;
                end
            endcase
        end else begin
            if (tok_reg == 2'd2) begin
                c.push_cnt = 2'd1;
                c.char0    = 8'h20;
            end
            tok_next       = 2'd0;
            held_char_next = 8'h00;
        end
        // Part end or stream end flushes an open token after the byte; space goes in the next free slot
        if (in_part_end || in_stream_end) begin
            if (tok_next == 2'd2) begin
                case (c.push_cnt)
                    2'd0:    c.char0 = 8'h20;
                    2'd1:    c.char1 = 8'h20;
                    default: c.char2 = 8'h20;
                endcase
                c.push_cnt = c.push_cnt + 2'd1;
            end
            tok_next        = 2'd0;
            held_char_next  = 8'h00;
            inside_tag_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_tag_reg <= 1'b0;
            held_char_reg  <= 8'h00;
            tok_reg        <= 2'd0;
        end else if (in_valid && cmd_ready) begin
            inside_tag_reg <= inside_tag_next;
            held_char_reg  <= held_char_next;
            tok_reg        <= tok_next;
        end
    end

    // A raw byte always pushes its own char, plus a space if a token was left open and the byte ends a part
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && scan_mode == MODE_RAW) |-> (c.push_cnt != 2'd0))
        else $error("raw mode must push its char");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && cmd_ready && (in_part_end || in_stream_end)) |=> (tok_reg == 2'd0))
        else $error("token state not cleared at part end");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_reg == 2'd0) |-> (held_char_reg == 8'h00))
        else $error("held char without open token");
endmodule

// File: rtl/core/kdc_fifo.sv
// Short command queue between front and back ends.
module kdc_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    input  kdc_pkg::kdc_cmd_t wr_data,
    output logic              wr_ready,
    output logic              rd_valid,
    output kdc_pkg::kdc_cmd_t rd_data,
    input  logic              rd_ready
);
    import kdc_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    kdc_cmd_t       mem_reg [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic           wr, rd;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!wr && !rd) |=> $stable(cnt_reg))
        else $error("count moved without access");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && !rd) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("count missed a write");
endmodule

// File: rtl/core/kdc_back.sv
// Back end: sliding window, marker compare, sticky found bits, scoring.
module kdc_back #(
    parameter int WINDOW_LEN   = 18,
    parameter int MARKER_COUNT = 32,
    parameter int SCHEMA_COUNT = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    input  kdc_pkg::kdc_cmd_t cmd,
    output logic              cmd_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata
);
    import kdc_pkg::*;

    logic [7:0]  win_reg [WINDOW_LEN];
    logic [7:0]  win1 [WINDOW_LEN];
    logic [7:0]  win2 [WINDOW_LEN];
    logic [7:0]  win3 [WINDOW_LEN];
    logic [31:0] found_reg, hit1, hit2, hit3, found_next;
    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_reg;
    logic        take;

    // Result register frees when empty or being taken
    assign cmd_ready = !out_valid_reg || m_tready;
    assign take      = cmd_valid && cmd_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign out_valid_next = (take && cmd.stream_end) ? 1'b1
                          : (m_tready ? 1'b0 : out_valid_reg);

    function automatic logic [31:0] match(input logic [7:0] w [WINDOW_LEN]);
        logic [31:0] r;
        mk_text_t    t;
        int          n;
        r = '0;
        for (int i = 0; i < MARKER_COUNT && i < TABLE_MARKERS; i++) begin
            t = mk_text(i);
            n = mk_len(i);
            if (n > 0 && n <= WINDOW_LEN) begin
                r[i] = 1'b1;
                for (int j = 0; j < MAX_LEN; j++)
                    if (j < n && w[WINDOW_LEN-n+j] != t[j*8 +: 8]) r[i] = 1'b0;
            end
        end
        return r;
    endfunction

    // Window after each of up to three pushes; match after each
    always_comb begin
        for (int i = 0; i < WINDOW_LEN-1; i++) win1[i] = win_reg[i+1];
        win1[WINDOW_LEN-1] = cmd.char0;
        for (int i = 0; i < WINDOW_LEN-1; i++) win2[i] = win1[i+1];
        win2[WINDOW_LEN-1] = cmd.char1;
        for (int i = 0; i < WINDOW_LEN-1; i++) win3[i] = win2[i+1];
        win3[WINDOW_LEN-1] = cmd.char2;
        hit1 = (cmd.push_cnt != 2'd0) ? match(win1) : '0;
        hit2 = (cmd.push_cnt >= 2'd2) ? match(win2) : '0;
        hit3 = (cmd.push_cnt == 2'd3) ? match(win3) : '0;
        found_next = found_reg | hit1 | hit2 | hit3;
    end

    // Winner selection, first schema with most hits
    logic [2:0]  best_idx;
    logic [3:0]  best_cnt;
    logic [8:0]  best_bits;
    always_comb begin
        logic [8:0] b;
        logic [3:0] k;
        best_idx = '0; best_cnt = '0; best_bits = '0;
        for (int s = 0; s < SCHEMA_COUNT && s < TABLE_SCHEMAS; s++) begin
            b = '0;
            for (int q = 0; q < MAX_SCHEMA_MK; q++)
                if (q < sc_count(s) && sc_first(s) + q < MARKER_COUNT
                    && sc_first(s) + q < TABLE_MARKERS)
                    b[q] = found_next[sc_first(s) + q];
            k = '0;
            for (int q = 0; q < MAX_SCHEMA_MK; q++) k = k + 4'(b[q]);
            if (k > best_cnt) begin
                best_cnt = k; best_idx = 3'(s + 1); best_bits = b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) win_reg[i] <= 8'h00;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                if (cmd.stream_end) begin
                    for (int i = 0; i < WINDOW_LEN; i++) win_reg[i] <= 8'h00;
                    found_reg <= '0;
                end else begin
                    if (cmd.push_cnt == 2'd3) win_reg <= win3;
                    else if (cmd.push_cnt == 2'd2) win_reg <= win2;
                    else if (cmd.push_cnt == 2'd1) win_reg <= win1;
                    found_reg <= found_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && cmd.stream_end)
            out_reg <= {found_next, best_bits, best_cnt, best_idx};
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> out_valid_reg)
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && cmd.stream_end) |=> (found_reg == '0))
        else $error("found bits not cleared");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !cmd.stream_end) |=> ((found_reg & $past(found_reg)) == $past(found_reg)))
        else $error("found bit lost");
endmodule

// File: rtl/core/keyword_domain_classifier.sv
// Top level: keyword domain classifier, front end, queue and back end.
// Throughput: one byte per cycle, sustained, unless a pending result held off by m_tready stalls the input.
// A stream end byte's command passes through the command queue and then the result
// register before its result is presented on m_tdata.
// Reset (aresetn low, synchronous) clears window, found bits, token and tag
// state and sets scan_mode to 2; no clearing pass is needed.
module keyword_domain_classifier #(
    parameter int WINDOW_LEN   = 18,
    parameter int MARKER_COUNT = 32,
    parameter int SCHEMA_COUNT = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,      // scan_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // data_byte
    input  logic        s_tlast,       // part_end
    input  logic        s_tuser,       // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata        // schema_index[2:0], hit_count[6:3],
                                       // winner_markers[15:7], all_found[47:16]
);
    import kdc_pkg::*;

    logic [1:0] mode_reg;
    logic       fv, fr, qv, qr;
    kdc_cmd_t   fcmd, qcmd;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) mode_reg <= MODE_STRIP;
        else if (cfg_valid) mode_reg <= cfg_data;
    end

    kdc_front u_front (
        .aclk, .aresetn, .scan_mode(mode_reg),
        .in_valid(s_tvalid), .in_byte(s_tdata), .in_part_end(s_tlast),
        .in_stream_end(s_tuser), .in_ready(s_tready),
        .cmd_valid(fv), .cmd(fcmd), .cmd_ready(fr)
    );

    kdc_fifo #(.DEPTH(2)) u_fifo (
        .aclk, .aresetn, .wr_valid(fv), .wr_data(fcmd), .wr_ready(fr),
        .rd_valid(qv), .rd_data(qcmd), .rd_ready(qr)
    );

    kdc_back #(
        .WINDOW_LEN(WINDOW_LEN), .MARKER_COUNT(MARKER_COUNT),
        .SCHEMA_COUNT(SCHEMA_COUNT)
    ) u_back (
        .aclk, .aresetn, .cmd_valid(qv), .cmd(qcmd), .cmd_ready(qr),
        .m_tvalid, .m_tready, .m_tdata
    );
endmodule

// File: tb/sv/kdc_checker.sv
// Checker: watches the byte and result channels, predicts classifications and compares.
module kdc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import kdc_pkg::*;

    localparam int WIN = 18;

    typedef struct packed {
        logic [31:0] all_found;
        logic [8:0]  winner_markers;
        logic [3:0]  hit_count;
        logic [2:0]  schema_index;
    } verdict_t;

    // predictor state
    logic [1:0]  mode_q;
    logic [7:0]  win_q [WIN];
    logic [31:0] found_q;
    logic        in_tag_q;
    logic [7:0]  held_q;
    logic [1:0]  tok_q;
    verdict_t    verdicts [$];

    // shift a character into the window and match all markers
    task automatic shift_in(input logic [7:0] c);
        int n;
        logic ok;
        mk_text_t t;
        for (int i = 0; i < WIN - 1; i++) win_q[i] = win_q[i+1];
        win_q[WIN-1] = c;
        for (int m = 0; m < TABLE_MARKERS; m++) begin
            n = mk_len(m);
            t = mk_text(m);
            ok = (n > 0 && n <= WIN);
            for (int k = 0; k < n && ok; k++)
                if (win_q[WIN-n+k] != t[k*8 +: 8]) ok = 0;
            if (ok) found_q[m] = 1'b1;
        end
    endtask

    task automatic close_token();
        if (tok_q == 2) shift_in(8'h20);
        tok_q = 0;
        held_q = 0;
    endtask

    task automatic clear_doc();
        for (int i = 0; i < WIN; i++) win_q[i] = 8'h00;
        found_q = 0;
        in_tag_q = 0;
        held_q = 0;
        tok_q = 0;
    endtask

    // tokenizer path for one byte
    task automatic token_char(input logic [7:0] c, input logic strip);
        logic [7:0] lc;
        if (c == 8'h00) return;
        if (strip) begin
            if (c == "<") begin
                in_tag_q = 1;
                close_token();
                return;
            end
            if (c == ">") begin
                in_tag_q = 0;
                return;
            end
            if (in_tag_q) return;
        end
        if (c >= 8'd32 && c < 8'd127 && c != " " && c != "," && c != ";") begin
            lc = to_lower_tb(c);
            if (tok_q == 0) begin
                held_q = lc;
                tok_q = 1;
            end else if (tok_q == 1) begin
                shift_in(held_q);
                shift_in(lc);
                tok_q = 2;
            end else begin
                shift_in(lc);
            end
        end else begin
            close_token();
        end
    endtask

    function automatic logic [7:0] to_lower_tb(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) ? c | 8'h20 : c;
    endfunction

    // one accepted byte; a stream end queues the expected verdict
    task automatic classify_byte(input logic [7:0] c, input logic pe, input logic se);
        verdict_t v;
        logic [8:0] bits;
        int cnt, best;
        if (mode_q == MODE_RAW) shift_in(to_lower_tb(c));
        else token_char(c, mode_q != MODE_TOKEN);
        if (pe || se) begin
            close_token();
            in_tag_q = 0;
        end
        if (!se) return;
        v = '0;
        best = 0;
        for (int s = 0; s < 6; s++) begin
            bits = 0;
            for (int k = 0; k < sc_count(s); k++)
                bits[k] = found_q[sc_first(s) + k];
            cnt = $countones(bits);
            if (cnt > best) begin
                best = cnt;
                v.schema_index = 3'(s + 1);
                v.winner_markers = bits;
            end
        end
        v.hit_count = 4'(best);
        v.all_found = found_q;
        verdicts.insert(verdicts.size(), v);
        clear_doc();
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        result_count = 0;
        mode_q = MODE_STRIP;
        clear_doc();
    end

    assign pending_count = verdicts.size();

    always @(posedge aclk) begin
        verdict_t got, want;
        if (!aresetn) begin
            mode_q = MODE_STRIP;
            clear_doc();
            verdicts.delete();
        end else begin
            // compare results first, they were computed from earlier bytes
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                result_count++;
                if (verdicts.size() == 0) begin
                    report("unexpected result", m_tdata[31:0], 32'd0);
                end else begin
                    want = verdicts.pop_front();
                    if (got.schema_index != want.schema_index)
                        report("schema_index", 32'(got.schema_index),
                               32'(want.schema_index));
                    if (got.hit_count != want.hit_count)
                        report("hit_count", 32'(got.hit_count), 32'(want.hit_count));
                    if (got.winner_markers != want.winner_markers)
                        report("winner_markers", 32'(got.winner_markers),
                               32'(want.winner_markers));
                    if (got.all_found != want.all_found)
                        report("all_found", got.all_found, want.all_found);
                end
            end
            if (cfg_valid && cfg_ready) mode_q = cfg_data;
            if (s_tvalid && s_tready) classify_byte(s_tdata, s_tlast, s_tuser);
        end
    end
endmodule

// File: tb/sv/tb.sv
// Testbench top: drives documents and mode writes into the classifier, gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kdc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // data_byte
    logic        s_tlast;      // part_end
    logic        s_tuser;      // stream_end
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;      // schema_index, hit_count, winner_markers, all_found
    int          fail_count, pending_count, result_count;
    int          send_idle_pct, recv_idle_pct, cycle_count, bytes_sent;
    bit          hold_recv;

    keyword_domain_classifier dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    kdc_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end

    // send one byte, with random idle before it
    task automatic send_byte(input logic [7:0] c, input logic pe, input logic se);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= pe;
        s_tuser <= se;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string t, input logic pe, input logic se);
        for (int i = 0; i < t.len(); i++)
            send_byte(t[i], pe && i == t.len() - 1, se && i == t.len() - 1);
    endtask

    // write scan_mode once the block has drained
    task automatic set_mode(input logic [1:0] m);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random byte biased toward marker letters, separators and tags
    function automatic logic [7:0] pick_byte();
        string alpha = "abcdefghiklmnoprstuvxy_ 15<>,;";
        case ($urandom_range(9))
            0: return 8'($urandom);
            1: return "<";
            2: return ">";
            3: return 8'h00;
            4: return alpha[$urandom_range(alpha.len() - 1)] & 8'hDF;
            default: return alpha[$urandom_range(alpha.len() - 1)];
        endcase
    endfunction

    // one random document: marker words mixed with noise, with random part ends
    task automatic send_document(input int maxlen);
        string words[12] = '{{"ms_", "summary"}, "StringerFemLoads", "Bay ID", "bacr15fv",
            "moment of inertia", {"sigma_", "cr"}, "BUCKLING", "rivet diameter",
            "<b>bolt</b> torque", "kc", "nxy", "x"};
        int n;
        n = $urandom_range(maxlen, 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(2) == 0) begin
                send_text(words[$urandom_range(11)], $urandom_range(7) == 0, 1'b0);
                send_byte(" ", 1'b0, 1'b0);
            end else begin
                send_byte(pick_byte(), $urandom_range(15) == 0, 1'b0);
            end
        end
        send_byte(pick_byte(), 1'b0, 1'b1);
    endtask

    initial begin
        logic [1:0] modes[4] = '{MODE_RAW, MODE_TOKEN, MODE_STRIP, 2'd3};
        aresetn = 0;
        cfg_valid = 0;
        cfg_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        s_tuser = 0;
        hold_recv = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        bytes_sent = 0;
        cycle_count = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset mode strips tags, markers, unknown, extremes, then token, raw and mode 3
        send_text({"<ms_", "summary> Ms_Summary,bay id;"}, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_text("bay", 1'b1, 1'b0);
        send_text(" id", 1'b0, 1'b1);
        send_text("a b", 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        set_mode(MODE_TOKEN);
        send_text("<kc> nx", 1'b0, 1'b1);
        set_mode(MODE_RAW);
        send_text("MOMENT OF INERTIA", 1'b0, 1'b1);
        set_mode(2'd3);
        send_text({"<x>sigma_", "cr"}, 1'b1, 1'b1);

        // random phases with changing idle patterns and modes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 86 : 0;
            recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 10 : 0;
            for (int d = 0; d < 12; d++) begin
                set_mode(modes[$urandom_range(3)]);
                for (int k = 0; k < 2; k++)
                    send_document(((d % 5) == 0) ? 14 : 6);
            end
            // mode change mid-stream: token left open across the write
            send_text("rive", 1'b0, 1'b0);
            set_mode(MODE_RAW);
            send_text("t", 1'b1, 1'b1);
        end

        // receiver holds off while short documents keep coming
        send_idle_pct = 0;
        fork
            begin
                hold_recv = 1;
                repeat (300) @(posedge aclk);
                hold_recv = 0;
            end
            for (int d = 0; d < 20; d++) send_text("kc", 1'b0, 1'b1);
        join
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("sent %0d bytes, checked %0d classifications", bytes_sent, result_count);
        $display("covered all scan modes, tags, parts, idle mixes and a long output stall");
        if (fail_count == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
